### rtl/core/assert_macros.svh
// Assertion macros shared by the stack and ranking modules.
// No dependencies; each file that checks itself includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/core/lsk_pkg.sv
// Shared constants, codes and types for the LIFO stack with top-score select.
// No dependencies; used by lsk_rank and lifo_stack_top_k_select.
package lsk_pkg;

  localparam int DEPTH     = 16;
  localparam int TOP_COUNT = 3;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int TOP_W     = $clog2(TOP_COUNT + 1);
  localparam int ID_W      = 16;
  localparam int SCORE_W   = 16;

  // Operation codes of an input item.
  localparam logic [1:0] FUNC_PUSH  = 2'd0;
  localparam logic [1:0] FUNC_POP   = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  // Status codes of a result item.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ONE,
    S_SCAN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [SCORE_W-1:0] sc;
  } entry_t;

  // Control from the sequencer to the ranking list.
  typedef struct packed {
    logic clear;
    logic ins;
    logic shift;
  } rank_ctrl_t;

endpackage

### rtl/core/lsk_rank.sv
// Sorted list of the best TOP_COUNT entries seen during a stack scan.
// Depends on lsk_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lsk_rank import lsk_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  rank_ctrl_t ctrl,
  input  entry_t     ins_entry,
  output entry_t     head,
  output logic       head_vld
);

  entry_t               ent [TOP_COUNT];
  logic [TOP_COUNT-1:0] vld;

  entry_t               ent_next [TOP_COUNT];
  logic [TOP_COUNT-1:0] vld_next;
  logic [TOP_COUNT-1:0] here;
  logic [TOP_COUNT-1:0] here_prev;
  entry_t               ent_prev [TOP_COUNT];
  entry_t               ent_up   [TOP_COUNT];
  logic [TOP_COUNT-1:0] vld_prev;
  logic [TOP_COUNT-1:0] vld_up;

  // Neighbor views of the list, one place up and one place down.
  always_comb begin
    here_prev[0] = 1'b0;
    ent_prev[0]  = ent[0];
    vld_prev[0]  = 1'b0;
    for (int k = 0; k < TOP_COUNT; k++) begin
      // Scan order is oldest first, so an equal score never displaces an older entry.
      here[k] = !vld[k] || (ins_entry.sc > ent[k].sc);
    end
    for (int k = 1; k < TOP_COUNT; k++) begin
      here_prev[k] = here[k-1];
      ent_prev[k]  = ent[k-1];
      vld_prev[k]  = vld[k-1];
    end
    for (int k = 0; k < TOP_COUNT - 1; k++) begin
      ent_up[k] = ent[k+1];
      vld_up[k] = vld[k+1];
    end
    ent_up[TOP_COUNT-1] = ent[TOP_COUNT-1];
    vld_up[TOP_COUNT-1] = 1'b0;
  end

  // Clear the list, insert the new entry at its place, pushing weaker ones down, or pop the head.
  always_comb begin
    vld_next = vld;
    for (int k = 0; k < TOP_COUNT; k++) begin
      ent_next[k] = ent[k];
    end
    if (ctrl.clear) begin
      vld_next = '0;
    end else if (ctrl.ins) begin
      for (int k = 0; k < TOP_COUNT; k++) begin
        if (here[k] && !here_prev[k]) begin
          ent_next[k] = ins_entry;
          vld_next[k] = 1'b1;
        end else if (here_prev[k]) begin
          ent_next[k] = ent_prev[k];
          vld_next[k] = vld_prev[k];
        end
      end
    end else if (ctrl.shift) begin
      for (int k = 0; k < TOP_COUNT; k++) begin
        ent_next[k] = ent_up[k];
      end
      vld_next = vld_up;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
    for (int k = 0; k < TOP_COUNT; k++) begin
      ent[k] <= ent_next[k];
    end
  end

  assign head     = ent[0];
  assign head_vld = vld[0];

  // Valid places always form an unbroken run from the head.
  `ASSERT_ALWAYS(a_vld_contig, clk, rst, ((TOP_COUNT'(vld + 1'b1)) & vld) == '0, "rank list has a gap")
  // The list is never filled and drained in the same cycle.
  `ASSERT_ALWAYS(a_ins_xor_shift, clk, rst, !(ctrl.ins && ctrl.shift), "insert during shift")

endmodule

### rtl/core/lifo_stack_top_k_select.sv
// Top level: bounded LIFO stack of (id, score) entries with a top-score query.
// Depends on lsk_pkg, lsk_rank and assert_macros.svh.
//
//  channel | direction | handshake            | payload
//  input   | in        | in_valid / in_stall  | func, entry_id, score
//  result  | out       | out_valid / out_stall| status, out_id, out_score, rank, last
//
// Push, pop and an empty query are accepted while idle and post their result once the output register is free.
// A query on N entries scans the entry memory, one read a cycle (the read port sets this),
// then posts min(N, TOP_COUNT) results, each one as the output register is free.
// Items are taken one at a time; an unused operation code is taken and dropped.
// Reset empties the stack at once; memory contents are not cleared.
// A stalled result holds in the output register; the next item may be taken meanwhile.
`include "assert_macros.svh"

module lifo_stack_top_k_select import lsk_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         func,
  input  logic [ID_W-1:0]    entry_id,
  input  logic [SCORE_W-1:0] score,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [ID_W-1:0]    out_id,
  output logic [SCORE_W-1:0] out_score,
  output logic [1:0]         rank,
  output logic               last
);

  state_t state;
  state_t state_next;

  entry_t mem [DEPTH];
  entry_t rd_data;
  logic   rd_vld;

  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] issue_cnt;
  logic [TOP_W-1:0] emit_cnt;
  logic [TOP_W-1:0] want;
  logic [1:0]       pend_status;

  logic       accept;
  logic       out_free;
  logic       is_full;
  logic       is_empty;
  logic       mem_we;
  logic       rd_issue;
  logic       emit_last;
  rank_ctrl_t rctl;
  entry_t     head;
  logic       head_vld;
  entry_t     wr_entry;

  assign is_full   = (fill_count == CNT_W'(DEPTH));
  assign is_empty  = (fill_count == '0);
  assign out_free  = !out_valid || !out_stall;
  assign emit_last = (TOP_W'(emit_cnt + 1'b1) == want);
  assign wr_entry  = '{id: entry_id, sc: score};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (func)
            FUNC_PUSH:  state_next = S_ONE;
            FUNC_POP:   state_next = S_ONE;
            FUNC_QUERY: state_next = is_empty ? S_ONE : S_SCAN;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (issue_cnt == fill_count && !rd_vld) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free && emit_last) begin
          state_next = S_IDLE;
        end
      end
      S_ONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_stall   = (state != S_IDLE);
    accept     = in_valid && (state == S_IDLE);
    mem_we     = accept && (func == FUNC_PUSH) && !is_full;
    rd_issue   = (state == S_SCAN) && (issue_cnt != fill_count);
    rctl.clear = accept && (func == FUNC_QUERY);
    rctl.ins   = rd_vld;
    rctl.shift = (state == S_EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Entry memory: one write port for push, one read port for the scan.
  // Writes happen only while idle, so a scan never overlaps a write.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill_count[ADDR_W-1:0]] <= wr_entry;
    end
    if (rd_issue) begin
      rd_data <= mem[issue_cnt[ADDR_W-1:0]];
    end
  end

  // Fill count, scan address and read-valid tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      issue_cnt  <= '0;
      rd_vld     <= 1'b0;
    end else begin
      rd_vld <= rd_issue;
      if (rd_issue) begin
        issue_cnt <= issue_cnt + 1'b1;
      end
      if (accept) begin
        issue_cnt <= '0;
        case (func)
          FUNC_PUSH: begin
            if (!is_full) begin
              fill_count <= fill_count + 1'b1;
            end
          end
          FUNC_POP: begin
            if (!is_empty) begin
              fill_count <= fill_count - 1'b1;
            end
          end
          default: fill_count <= fill_count;
        endcase
      end
    end
  end

  // Status of a single-result item and the result count of a query.
  always_ff @(posedge clk) begin
    if (accept) begin
      case (func)
        FUNC_PUSH: pend_status <= is_full ? ST_FULL : ST_OK;
        default:   pend_status <= is_empty ? ST_EMPTY : ST_OK;
      endcase
      if (32'(fill_count) < TOP_COUNT) begin
        want <= TOP_W'(fill_count);
      end else begin
        want <= TOP_W'(TOP_COUNT);
      end
    end
  end

  // Result counter for a query.
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_cnt <= '0;
    end else if (rctl.clear) begin
      emit_cnt <= '0;
    end else if (rctl.shift) begin
      emit_cnt <= emit_cnt + 1'b1;
    end
  end

  lsk_rank u_rank (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (rctl),
    .ins_entry (rd_data),
    .head      (head),
    .head_vld  (head_vld)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_ONE && out_free) begin
      out_valid <= 1'b1;
    end else if (state == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_ONE && out_free) begin
      status    <= pend_status;
      out_id    <= '0;
      out_score <= '0;
      rank      <= '0;
      last      <= 1'b1;
    end else if (state == S_EMIT && out_free) begin
      status    <= ST_OK;
      out_id    <= head.id;
      out_score <= head.sc;
      rank      <= 2'(emit_cnt);
      last      <= emit_last;
    end
  end

  // Every result posted from a query comes from a filled place of the list.
  `ASSERT_IMPLIES(a_emit_has_entry, clk, rst, state == S_EMIT, head_vld, "query result without entry")
  // The stack size never changes while a scan is under way.
  `ASSERT_IMPLIES(a_scan_fill_stable, clk, rst, (state == S_SCAN) && $past(state == S_SCAN), $stable(fill_count), "fill count moved during scan")
  // The fill count never exceeds the stack depth.
  `ASSERT_ALWAYS(a_fill_bound, clk, rst, 32'(fill_count) <= DEPTH, "fill count beyond depth")

endmodule

### sim/lifo_stack_top_k_select_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for lifo_stack_top_k_select: push, pop and top-score query
// items are driven and every result is compared with a stack predictor.
// Depends on lsk_pkg and the RTL of lifo_stack_top_k_select.
module lifo_stack_top_k_select_tb;
  import lsk_pkg::*;

  // The fourth operation code has no meaning and is dropped by the block.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int NUM_ITEMS   = 220;
  localparam int PHASE_LEN   = 40;
  localparam int DRAIN_WAIT  = 40;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    logic [1:0]         op;
    logic [ID_W-1:0]    id;
    logic [SCORE_W-1:0] sc;
    int                 mode;
    bit                 drain;
  } stack_op_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ID_W-1:0]    id;
    logic [SCORE_W-1:0] sc;
    logic [1:0]         rank;
    logic               last;
  } reply_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         func = FUNC_PUSH;
  logic [ID_W-1:0]    entry_id = '0;
  logic [SCORE_W-1:0] score = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status;
  logic [ID_W-1:0]    out_id;
  logic [SCORE_W-1:0] out_score;
  logic [1:0]         rank;
  logic               last;

  stack_op_t op_q[$];
  reply_t    reply_q[$];

  // Predictor state: slot 0 holds the oldest entry.
  logic [ID_W-1:0]    id_mem[DEPTH];
  logic [SCORE_W-1:0] score_mem[DEPTH];
  int                 held = 0;

  int mode_now = 0;
  int n_ops = 0;
  int n_real = 0;
  int prev_mode = 0;
  int errors = 0;
  int n_checked = 0;
  int n_queries = 0;
  int n_full = 0;
  int n_empty = 0;
  int cycles = 0;

  lifo_stack_top_k_select i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .entry_id  (entry_id),
    .score     (score),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .out_id    (out_id),
    .out_score (out_score),
    .rank      (rank),
    .last      (last)
  );

  always #4 clk = ~clk;

  // Idle and stall rates of each phase, in percent.
  function automatic int send_idle_pct(int m);
    case (m)
      1: return 59;
      3: return 12;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct(int m);
    case (m)
      2: return 59;
      3: return 12;
      default: return 0;
    endcase
  endfunction

  // Higher score wins; on equal scores the deeper slot wins.
  function automatic bit ranks_ahead(int a, int b);
    if (score_mem[a] != score_mem[b]) return score_mem[a] > score_mem[b];
    return a < b;
  endfunction

  // Updates the stack copy for one accepted item and queues its results.
  task automatic stack_predict(logic [1:0] op, logic [ID_W-1:0] id, logic [SCORE_W-1:0] sc);
    reply_t r;
    int     want;
    int     best;
    int     prev;
    r = '0;
    r.last = 1'b1;
    prev = 0;
    case (op)
      FUNC_PUSH: begin
        if (held == DEPTH) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          id_mem[held] = id;
          score_mem[held] = sc;
          held++;
          r.status = ST_OK;
        end
        reply_q.push_back(r);
      end
      FUNC_POP: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
          n_empty++;
        end else begin
          held--;
          r.status = ST_OK;
        end
        reply_q.push_back(r);
      end
      FUNC_QUERY: begin
        n_queries++;
        if (held == 0) begin
          r.status = ST_EMPTY;
          n_empty++;
          reply_q.push_back(r);
        end else begin
          want = (held < TOP_COUNT) ? held : TOP_COUNT;
          for (int k = 0; k < want; k++) begin
            best = -1;
            for (int i = 0; i < held; i++) begin
              if (k > 0 && !ranks_ahead(prev, i)) continue;
              if (best < 0 || ranks_ahead(i, best)) best = i;
            end
            r = '0;
            r.status = ST_OK;
            r.id = id_mem[best];
            r.sc = score_mem[best];
            r.rank = 2'(k);
            r.last = (k == want - 1);
            reply_q.push_back(r);
            prev = best;
          end
        end
      end
      default: ;
    endcase
  endtask

  // Queues one item; the idle and stall phase follows the item count and every phase
  // change first waits for the block to drain.
  task automatic add_op(logic [1:0] op, logic [ID_W-1:0] id, logic [SCORE_W-1:0] sc);
    stack_op_t t;
    t.op = op;
    t.id = id;
    t.sc = sc;
    t.mode = (n_ops / PHASE_LEN) % 4;
    t.drain = (t.mode != prev_mode);
    prev_mode = t.mode;
    op_q.push_back(t);
    n_ops++;
    if (op != FUNC_UNUSED) n_real++;
  endtask

  // Scores lean toward ties and extremes so that the ranking order is exercised.
  function automatic logic [SCORE_W-1:0] pick_score();
    case ($urandom_range(3))
      0: return SCORE_W'($urandom_range(3));
      1: return $urandom_range(1) ? '1 : '0;
      default: return SCORE_W'($urandom);
    endcase
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    return ID_W'($urandom);
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, act_val);
    end
  endtask

  // Cycle counter with a hard stop.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected", cycles, reply_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Driver: predicts each accepted item and presents the next one from the queue.
  always @(posedge clk) begin
    stack_op_t nxt;
    logic      drive;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) stack_predict(func, entry_id, score);
      if (!(in_valid && in_stall)) begin
        drive = 1'b0;
        if (op_q.size() > 0) begin
          if (!(op_q[0].drain && reply_q.size() != 0) &&
              $urandom_range(99) >= send_idle_pct(op_q[0].mode)) begin
            nxt = op_q.pop_front();
            func <= nxt.op;
            entry_id <= nxt.id;
            score <= nxt.sc;
            mode_now <= nxt.mode;
            drive = 1'b1;
          end
        end
        in_valid <= drive;
      end
    end
  end

  // Monitor: checks each accepted result against the oldest expectation.
  always @(posedge clk) begin
    reply_t e;
    if (!rst && out_valid && !out_stall) begin
      n_checked++;
      if (reply_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, got status %0h id %0h score %0h rank %0d last %0b",
                 $time, status, out_id, out_score, rank, last);
      end else begin
        e = reply_q.pop_front();
        check_field("status", e.status, status);
        check_field("out_id", e.id, out_id);
        check_field("out_score", e.sc, out_score);
        check_field("rank", e.rank, rank);
        check_field("last", e.last, last);
      end
    end
    out_stall <= !rst && ($urandom_range(99) < recv_stall_pct(mode_now));
  end

  // Stimulus and end of run.
  initial begin
    int len;
    int r;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty stack, extremes, ties, a dropped code, draining to empty.
    add_op(FUNC_QUERY, '1, '1);
    add_op(FUNC_POP, '1, '1);
    add_op(FUNC_PUSH, '1, '1);
    add_op(FUNC_QUERY, '0, '0);
    add_op(FUNC_PUSH, '0, '0);
    add_op(FUNC_PUSH, 16'h1234, '1);
    add_op(FUNC_PUSH, 16'h00FF, 16'h8000);
    add_op(FUNC_PUSH, 16'hA5A5, '0);
    add_op(FUNC_QUERY, '0, '0);
    add_op(FUNC_UNUSED, '1, '1);
    add_op(FUNC_POP, '0, '0);
    add_op(FUNC_POP, '0, '0);
    add_op(FUNC_QUERY, '0, '0);
    add_op(FUNC_POP, '0, '0);
    add_op(FUNC_QUERY, '0, '0);
    add_op(FUNC_POP, '0, '0);
    add_op(FUNC_POP, '0, '0);
    add_op(FUNC_QUERY, '0, '0);

    // Random: push bursts that often hit the full stack, pop bursts, and mixed items.
    while (n_real < NUM_ITEMS) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          len = $urandom_range(3, 20);
          repeat (len) add_op(FUNC_PUSH, pick_id(), pick_score());
          add_op(FUNC_QUERY, pick_id(), pick_score());
        end
        3: begin
          len = $urandom_range(1, 8);
          repeat (len) add_op(FUNC_POP, pick_id(), pick_score());
        end
        default: begin
          r = $urandom_range(19);
          if (r < 8) add_op(FUNC_PUSH, pick_id(), pick_score());
          else if (r < 13) add_op(FUNC_POP, pick_id(), pick_score());
          else if (r < 19) add_op(FUNC_QUERY, pick_id(), pick_score());
          else add_op(FUNC_UNUSED, pick_id(), pick_score());
        end
      endcase
    end

    while (op_q.size() != 0 || in_valid || reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Run covered %0d items (%0d queries, %0d rejected pushes, %0d empty replies)",
             n_ops, n_queries, n_full, n_empty);
    $display("and checked %0d results over four idle and stall phases.", n_checked);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/lsk_pkg.sv
rtl/core/lsk_rank.sv
rtl/core/lifo_stack_top_k_select.sv
sim/lifo_stack_top_k_select_tb.sv
